// ===== hw/rtl/mbq_pkg.sv =====
// Shared constants and types for the multichannel biquad unit.
// No dependencies; imported by every module of the block.
package mbq_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;
  localparam int CHAN_W      = 3;
  localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COEF_W      = 32;
  localparam int FRAC_BITS   = 28;
  localparam int CFG_IDX_W   = 3;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  // exact 32x24 product, and room for five of them plus the rounding bias
  localparam int PROD_W      = COEF_W + SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  // one queued sample, tagged by the front end
  typedef struct packed {
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          in_range;
  } q_item_t;

endpackage

// ===== hw/rtl/multichannel_biquad_df1_unit.sv =====
// Top level of the multichannel direct-form-1 biquad: coefficient registers,
// input queue (mbq_front) and filter engine (mbq_back). Depends on mbq_pkg.
//
// Each sample on the slave stream runs one second-order IIR section for its
// channel, y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, with Q4.28 coefficients
// shared by all channels, rounded to nearest (ties up) and saturated to the
// sample width; the result leaves on the master stream tagged with the same
// channel. History for every channel is zero after reset. The engine steps
// its two multipliers through the five products in S_MUL0, S_MUL1 and
// S_MUL2 and finishes the sum in S_FIN, where it takes the next queued
// sample, if any, as the result goes out. A two-entry queue at the input
// and a result register at the output let either stream stall without
// blocking the other. Coefficients are written at cfg_index 0..4 (b0, b1,
// b2, a1, a2); the user must write them only while no sample is in flight,
// which the block itself does not enforce; other indexes are ignored.
module multichannel_biquad_df1_unit import mbq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TDATA_W-1:0]   s_tdata,   // [23:0] sample_in
  input  logic [CHAN_W-1:0]    s_tuser,   // [2:0] chan
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // [23:0] sample_out
  output logic [CHAN_W-1:0]    m_tuser,   // [2:0] chan_out
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  coef_set_t                     coef;
  logic                          q_valid;
  q_item_t                       q_item;
  logic                          q_pop;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= COEF_W'(64'sd1 <<< FRAC_BITS);
      coef.b1 <= '0;
      coef.b2 <= '0;
      coef.a1 <= '0;
      coef.a2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (coef_idx_t'(cfg_index))
        COEF_B0: coef.b0 <= cfg_data;
        COEF_B1: coef.b1 <= cfg_data;
        COEF_B2: coef.b2 <= cfg_data;
        COEF_A1: coef.a1 <= cfg_data;
        COEF_A2: coef.a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  mbq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mbq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_chan   (m_tuser),
    .out_sample (out_sample)
  );

  assign m_tdata = TDATA_W'(unsigned'(out_sample));

endmodule

// ===== hw/rtl/mbq_front.sv =====
// Input side: accepts samples, flags out-of-range channels, and buffers
// them in a two-entry queue for the filter engine. Depends on mbq_pkg.
module mbq_front import mbq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample_in, rest zero
  input  logic [CHAN_W-1:0]      s_tuser,   // [2:0] chan
  output logic                   q_valid,
  output q_item_t                q_item,
  input  logic                   q_pop
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  q_item_t            new_item;

  assign s_tready = (count != CNT_W'(DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  always_comb begin
    new_item.chan     = s_tuser;
    new_item.sample   = $signed(s_tdata[SAMPLE_BITS-1:0]);
    new_item.in_range = (32'(s_tuser) < CHANNELS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= new_item;
        wr_ptr          <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mbq_back.sv =====
// Filter engine: per-channel history, two multipliers stepped through the
// S_MUL states, rounding, saturation and the output register. Depends on mbq_pkg.
module mbq_back import mbq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  coef_set_t                     coef,
  input  logic                          q_valid,
  input  q_item_t                       q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHAN_W-1:0]             out_chan,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int Q_W = ACC_W - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [Q_W-1:0] Y_MAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Y_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_FIN
  } state_t;

  state_t state;

  logic signed [SAMPLE_BITS-1:0] in_d1  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] in_d2  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_d1 [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] out_d2 [CHANNELS];

  logic [CHAN_W-1:0]             cur_chan;
  logic                          cur_ok;
  logic signed [SAMPLE_BITS-1:0] op_x, op_x1, op_x2, op_y1, op_y2;
  logic signed [PROD_W-1:0]      p0, p1;
  logic signed [ACC_W-1:0]       acc;

  logic signed [ACC_W-1:0]       sum;
  logic signed [Q_W-1:0]         q;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SAMPLE_BITS-1:0] y_fin;
  logic                          fin_go;
  logic                          wb;
  logic                          same;
  logic [CHAN_IDX_W-1:0]         cur_idx;
  logic [CHAN_IDX_W-1:0]         nx_idx;
  logic signed [SAMPLE_BITS-1:0] nx_x1, nx_x2, nx_y1, nx_y2;

  always_comb begin
    // last product is a feedback term, so it is subtracted
    sum = acc - ACC_W'(p0);
    q   = $signed(sum[ACC_W-1:FRAC_BITS]);
    if (q > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (q < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = q[SAMPLE_BITS-1:0];
    end
    y_fin   = cur_ok ? y_sat : '0;
    fin_go  = (state == S_FIN) && (!out_valid || out_ready);
    wb      = fin_go && cur_ok;
    q_pop   = q_valid && ((state == S_IDLE) || fin_go);
    cur_idx = cur_chan[CHAN_IDX_W-1:0];
    nx_idx  = q_item.chan[CHAN_IDX_W-1:0];
    // forward the history being written this cycle to a same-channel successor
    same    = wb && (q_item.chan == cur_chan);
    nx_x1   = same ? op_x  : in_d1[nx_idx];
    nx_x2   = same ? op_x1 : in_d2[nx_idx];
    nx_y1   = same ? y_sat : out_d1[nx_idx];
    nx_y2   = same ? op_y1 : out_d2[nx_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        in_d1[i]  <= '0;
        in_d2[i]  <= '0;
        out_d1[i] <= '0;
        out_d2[i] <= '0;
      end
    end else begin
      if (fin_go) begin
        out_valid  <= 1'b1;
        out_chan   <= cur_chan;
        out_sample <= y_fin;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (wb) begin
        in_d1[cur_idx]  <= op_x;
        in_d2[cur_idx]  <= op_x1;
        out_d1[cur_idx] <= y_sat;
        out_d2[cur_idx] <= op_y1;
      end
      if (q_pop) begin
        cur_chan <= q_item.chan;
        cur_ok   <= q_item.in_range;
        op_x     <= q_item.sample;
        op_x1    <= nx_x1;
        op_x2    <= nx_x2;
        op_y1    <= nx_y1;
        op_y2    <= nx_y2;
      end

      case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0    <= PROD_W'(coef.b0) * PROD_W'(op_x);
          p1    <= PROD_W'(coef.b1) * PROD_W'(op_x1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= ACC_W'(p0) + ACC_W'(p1) + RND;
          p0    <= PROD_W'(coef.b2) * PROD_W'(op_x2);
          p1    <= PROD_W'(coef.a1) * PROD_W'(op_y1);
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + ACC_W'(p0) - ACC_W'(p1);
          p0    <= PROD_W'(coef.a2) * PROD_W'(op_y2);
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            state <= q_pop ? S_MUL0 : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
